[rtl/seven_segment_mux_counter_core_macros.svh]
// Assertion macros shared by the seven-segment counter RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SEVEN_SEGMENT_MUX_COUNTER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_MUX_COUNTER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSEG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/sseg_pkg.sv]
// Package for the seven-segment counter: sizes, register map, segment table,
// BCD helpers and the structs passed between modules. No dependencies.
package sseg_pkg;

  localparam int unsigned DIGITS     = 4;
  localparam int unsigned IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned LAST_IDX   = DIGITS - 1;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned SHOWN_W    = 14;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;
  localparam logic [7:0]         POS_UNITS   = 8'h80;

  // Word index of each configuration register.
  typedef enum logic [0:0] {
    REG_TICK_LIMIT = 1'b0
  } reg_idx_e;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                wr_en;
    logic [LIMIT_W-1:0]  limit;
  } cfg_wr_t;

  typedef struct packed {
    logic accept;
    logic tick;
  } step_t;

  // Active-low common-anode patterns; non-decimal codes blank the digit.
  function automatic logic [7:0] seg_lut(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // Ripple a +1 through the BCD digits, units (highest index) first.
  function automatic bcd_t bcd_inc(input bcd_t d);
    bcd_t r;
    logic carry;
    r     = d;
    carry = 1'b1;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (carry) begin
        if (r[k] >= 4'd9) begin
          r[k] = 4'd0;
        end else begin
          r[k]  = r[k] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Binary value of the BCD digits, kept modulo 2^SHOWN_W.
  function automatic logic [SHOWN_W-1:0] bcd_value(input bcd_t d);
    logic [SHOWN_W-1:0] s;
    s = '0;
    for (int k = 0; k < DIGITS; k++) begin
      s = SHOWN_W'(s * SHOWN_W'(10)) + SHOWN_W'(d[k]);
    end
    return s;
  endfunction

endpackage

[rtl/sseg_counter.sv]
// Tick prescaler, tick_limit register and BCD display count.
// Depends on sseg_pkg and the assertion macros header.
`include "seven_segment_mux_counter_core_macros.svh"

module sseg_counter
  import sseg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_wr_t            cfg_i,
  input  step_t              step_i,
  output logic [LIMIT_W-1:0] limit_o,
  output bcd_t               digits_o
);

  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [LIMIT_W-1:0] pre_q, pre_d, pre_inc;
  bcd_t               digits_q, digits_d;

  always_comb begin
    limit_d  = cfg_i.wr_en ? cfg_i.limit : limit_q;
    pre_inc  = pre_q + LIMIT_W'(1);
    pre_d    = pre_q;
    digits_d = digits_q;
    if (step_i.accept && step_i.tick) begin
      if (pre_inc > limit_q) begin
        pre_d    = '0;
        digits_d = bcd_inc(digits_q);
      end else begin
        pre_d = pre_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      pre_q    <= '0;
      digits_q <= '0;
    end else begin
      limit_q  <= limit_d;
      pre_q    <= pre_d;
      digits_q <= digits_d;
    end
  end

  assign limit_o  = limit_q;
  assign digits_o = digits_q;

  `SSEG_ASSERT(a_idle_holds_count, !(step_i.accept && step_i.tick) |=> $stable(digits_q), "count moved without a tick")
  `SSEG_ASSERT(a_wrap_clears_pre, !$stable(digits_q) |-> pre_q == '0, "count advanced but prescaler not cleared")
  `SSEG_ASSERT(a_digit_units_decimal, digits_q[LAST_IDX] <= 4'd9, "units digit left decimal range")

endmodule

[rtl/sseg_frame.sv]
// Frame sequencer: snapshots the count on each request and emits one frame
// per digit, thousands first. Depends on sseg_pkg and the assertion macros.
`include "seven_segment_mux_counter_core_macros.svh"

module sseg_frame
  import sseg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bcd_t               digits_i,
  output logic               ready_o,
  output logic               frame_valid_o,
  input  logic               frame_ready_i,
  output logic [7:0]         segment_pattern_o,
  output logic [7:0]         position_code_o,
  output logic [15:0]        frame_word_o,
  output logic [1:0]         digit_index_o,
  output logic [SHOWN_W-1:0] shown_count_o,
  output logic               last_frame_o
);

  bcd_t               snap_q, snap_d;
  logic [SHOWN_W-1:0] shown_q, shown_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               valid_q, valid_d;
  logic               is_last, out_take;
  logic [3:0]         shift_amt;
  logic [7:0]         idx_ext;

  assign is_last  = idx_q == IDX_W'(LAST_IDX);
  assign out_take = valid_q && frame_ready_i;
  assign ready_o  = !valid_q || (frame_ready_i && is_last);

  always_comb begin
    snap_d  = snap_q;
    shown_d = shown_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      snap_d  = digits_i;
      shown_d = bcd_value(digits_i);
      idx_d   = '0;
      valid_d = 1'b1;
    end else if (out_take) begin
      if (is_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = IDX_W'(idx_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q  <= snap_d;
    shown_q <= shown_d;
  end

  assign shift_amt         = 4'(LAST_IDX) - 4'(idx_q);
  assign idx_ext           = 8'(idx_q);
  assign segment_pattern_o = seg_lut(snap_q[idx_q]);
  assign position_code_o   = POS_UNITS >> shift_amt;
  assign frame_word_o      = {segment_pattern_o, position_code_o};
  assign digit_index_o     = idx_ext[1:0];
  assign shown_count_o     = shown_q;
  assign last_frame_o      = is_last;
  assign frame_valid_o     = valid_q;

  `SSEG_ASSERT(a_load_starts_first, load_i |=> valid_q && idx_q == '0, "request did not start at first digit")
  `SSEG_ASSERT(a_advance_by_one, out_take && !is_last && !load_i |=> valid_q && idx_q == IDX_W'($past(idx_q) + 1'b1), "digit index skipped")
  `SSEG_ASSERT(a_no_overrun, load_i |-> !valid_q || (out_take && is_last), "request taken mid-refresh")
  `SSEG_ASSERT(a_units_code, valid_q && is_last |-> position_code_o == POS_UNITS, "units frame has wrong position")

endmodule

[rtl/seven_segment_mux_counter_core.sv]
// The first frame of a request is valid the cycle after the request is taken.
// DIGITS frames (four) go out per request, one per cycle while frame_ready_i
// is high; the frame sequencer takes the next request as the units frame
// leaves. Reset (rst_ni low, asynchronous) clears the count and prescaler,
// loads tick_limit with 500 and drops any frames still pending.
//
// Top level: APB register decode, prescaler/count and frame sequencer.
// Depends on sseg_pkg, sseg_counter and sseg_frame.
module seven_segment_mux_counter_core
  import sseg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  // Refresh requests
  input  logic               tick_valid_i,
  output logic               tick_ready_o,
  input  logic               tick_i,
  // Frames
  output logic               frame_valid_o,
  input  logic               frame_ready_i,
  output logic [7:0]         segment_pattern_o,
  output logic [7:0]         position_code_o,
  output logic [15:0]        frame_word_o,
  output logic [1:0]         digit_index_o,
  output logic [SHOWN_W-1:0] shown_count_o,
  output logic               last_frame_o
);

  cfg_wr_t            cfg_wr;
  step_t              step;
  logic [LIMIT_W-1:0] limit;
  bcd_t               digits;
  reg_idx_e           reg_sel;
  logic               frame_ready_in;

  // Word-aligned decode: byte-lane bits are ignored.
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  // Commit a write in the access phase; only tick_limit exists.
  always_comb begin
    cfg_wr.wr_en = 1'b0;
    cfg_wr.limit = pwdata[LIMIT_W-1:0];
    prdata       = '0;
    unique case (reg_sel)
      REG_TICK_LIMIT: begin
        cfg_wr.wr_en = psel && penable && pwrite;
        prdata       = {{(APB_DW - LIMIT_W){1'b0}}, limit};
      end
      default: begin
        cfg_wr.wr_en = 1'b0;
      end
    endcase
  end

  // A request snapshots the count before this tick's increment, so the
  // sequencer and the counter both act on the same accept.
  assign step.accept = tick_valid_i && frame_ready_in;
  assign step.tick   = tick_i;
  assign tick_ready_o = frame_ready_in;

  sseg_counter u_counter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .step_i   (step),
    .limit_o  (limit),
    .digits_o (digits)
  );

  // Hold frames until taken; accept the next request as the units frame leaves.
  sseg_frame u_frame (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (step.accept),
    .digits_i          (digits),
    .ready_o           (frame_ready_in),
    .frame_valid_o     (frame_valid_o),
    .frame_ready_i     (frame_ready_i),
    .segment_pattern_o (segment_pattern_o),
    .position_code_o   (position_code_o),
    .frame_word_o      (frame_word_o),
    .digit_index_o     (digit_index_o),
    .shown_count_o     (shown_count_o),
    .last_frame_o      (last_frame_o)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for seven_segment_mux_counter_core: sends refresh requests,
// writes tick_limit over APB and checks every frame against its own prediction.
// Depends on sseg_pkg and the counter core RTL.
module tb;
  import sseg_pkg::*;

  // Percent of cycles in which each side holds off outside the steady stretch.
  localparam int unsigned IDLE_PCT    = 30;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Ticks at tick_limit = 0, each one advancing the count.
  localparam int unsigned SWEEP_TICKS = 120;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 18;

  localparam logic [APB_AW-1:0] LIMIT_ADDR    = APB_AW'(4 * REG_TICK_LIMIT);
  // Word slot with no register behind it; writes there must be dropped.
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(4);

  // Active-low common-anode patterns for digits 0..9, indexed by digit.
  localparam logic [9:0][7:0] GLYPH = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                       8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  typedef struct packed {
    logic [7:0]         seg;
    logic [7:0]         pos;
    logic [15:0]        word;
    logic [1:0]         idx;
    logic [SHOWN_W-1:0] shown;
    logic               last;
  } frame_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [APB_AW-1:0]  paddr         = '0;
  logic [APB_DW-1:0]  pwdata        = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               tick_valid_i  = 1'b0;
  logic               tick_ready_o;
  logic               tick_i        = 1'b0;
  logic               frame_valid_o;
  logic               frame_ready_i = 1'b0;
  logic [7:0]         segment_pattern_o;
  logic [7:0]         position_code_o;
  logic [15:0]        frame_word_o;
  logic [1:0]         digit_index_o;
  logic [SHOWN_W-1:0] shown_count_o;
  logic               last_frame_o;

  // Requests waiting to be driven, and frames predicted but not yet seen.
  logic   ticks_pending[$];
  frame_t refresh_frames_due[$];

  // Shadow of the block: limit register, prescaler and BCD count (index 0 = thousands).
  logic [LIMIT_W-1:0] limit_q    = LIMIT_RESET;
  logic [LIMIT_W-1:0] prescale_q = '0;
  logic [3:0]         digits_q [DIGITS];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  logic        steady         = 1'b0;  // when set, neither side idles

  seven_segment_mux_counter_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .tick_valid_i      (tick_valid_i),
    .tick_ready_o      (tick_ready_o),
    .tick_i            (tick_i),
    .frame_valid_o     (frame_valid_o),
    .frame_ready_i     (frame_ready_i),
    .segment_pattern_o (segment_pattern_o),
    .position_code_o   (position_code_o),
    .frame_word_o      (frame_word_o),
    .digit_index_o     (digit_index_o),
    .shown_count_o     (shown_count_o),
    .last_frame_o      (last_frame_o)
  );

  always #2 clk_i = ~clk_i;

  // Queue the four frames of one refresh, then, on a tick, advance prescaler and count.
  task automatic predict_refresh(input logic tick);
    frame_t      f;
    int unsigned acc;
    logic        carry;
    acc = 0;
    for (int k = 0; k < DIGITS; k++) begin
      acc = acc * 10 + digits_q[k];
    end
    for (int k = 0; k < DIGITS; k++) begin
      f.seg   = GLYPH[digits_q[k]];
      f.pos   = POS_UNITS >> (DIGITS - 1 - k);
      f.word  = {f.seg, f.pos};
      f.idx   = 2'(k);
      f.shown = SHOWN_W'(acc);
      f.last  = (k == DIGITS - 1);
      refresh_frames_due.push_back(f);
    end
    if (tick) begin
      prescale_q = prescale_q + 1'b1;
      if (prescale_q > limit_q) begin
        prescale_q = '0;
        // Ripple the increment from the units digit up; all nines wrap to zero.
        carry = 1'b1;
        for (int k = DIGITS - 1; k >= 0; k--) begin
          if (carry) begin
            if (digits_q[k] >= 4'd9) begin
              digits_q[k] = 4'd0;
            end else begin
              digits_q[k] = digits_q[k] + 4'd1;
              carry       = 1'b0;
            end
          end
        end
      end
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Two-phase APB write; the shadow limit follows only a write that hits the register.
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) begin
      limit_q = data[LIMIT_W-1:0];
    end
  endtask

  // Block until every queued request is taken and every predicted frame is back.
  task automatic wait_idle();
    while (ticks_pending.size() != 0 || tick_valid_i || refresh_frames_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // Request driver: predict on each accepted request, then present the next one
  // or hold off at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_i <= 1'b0;
      tick_i       <= 1'b0;
    end else begin
      if (tick_valid_i && tick_ready_o) begin
        predict_refresh(tick_i);
      end
      if (!tick_valid_i || tick_ready_o) begin
        if (ticks_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          tick_valid_i <= 1'b1;
          tick_i       <= ticks_pending.pop_front();
        end else begin
          tick_valid_i <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: compare each accepted frame with the oldest prediction and
  // stall the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      frame_ready_i <= 1'b0;
    end else begin
      if (frame_valid_o && frame_ready_i) begin
        if (refresh_frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got word 0x%0h", $time,
                   frame_word_o);
          mismatch_count++;
        end else begin
          want = refresh_frames_due.pop_front();
          check_field("segment_pattern", want.seg,   segment_pattern_o);
          check_field("position_code",   want.pos,   position_code_o);
          check_field("frame_word",      want.word,  frame_word_o);
          check_field("digit_index",     want.idx,   digit_index_o);
          check_field("shown_count",     want.shown, shown_count_o);
          check_field("last_frame",      want.last,  last_frame_o);
        end
      end
      frame_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_valid_i && tick_ready_o) || (frame_valid_o && frame_ready_i) || psel) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned next_limit;
    for (int k = 0; k < DIGITS; k++) begin
      digits_q[k] = 4'd0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limit: refresh only, then two ticks far below the limit.
    ticks_pending = '{1'b0, 1'b1, 1'b1};
    wait_idle();

    // Lowest limit: every tick advances the count; a zero tick leaves it alone.
    write_reg(LIMIT_ADDR, '0);
    ticks_pending = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    wait_idle();

    // Highest limit with all data bits set: the count must freeze.
    write_reg(LIMIT_ADDR, '1);
    ticks_pending = '{1'b1, 1'b1, 1'b1, 1'b1};
    wait_idle();

    // Write to an unmapped slot must be dropped, so the count stays frozen.
    write_reg(UNMAPPED_ADDR, '0);
    ticks_pending = '{1'b1, 1'b1, 1'b1};
    wait_idle();

    // Small limit: the leftover prescaler advances the count on the first tick, then on every third.
    write_reg(LIMIT_ADDR, APB_DW'(2));
    ticks_pending = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    wait_idle();

    // Run a stretch of ticks at the lowest limit, each advancing the count;
    // the first half goes with no idling on either side.
    write_reg(LIMIT_ADDR, '0);
    for (int i = 0; i < SWEEP_TICKS; i++) begin
      ticks_pending.push_back(1'b1);
    end
    steady = 1'b1;
    while (ticks_pending.size() > SWEEP_TICKS / 2) begin
      @(posedge clk_i);
    end
    steady = 1'b0;
    wait_idle();

    // Random phases: mostly ticks, under limits from the extremes and in between.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       next_limit = $urandom_range(7, 1);
        1:       next_limit = 65535;
        2:       next_limit = 0;
        3:       next_limit = $urandom_range(65535, 0);
        4:       next_limit = 1;
        default: next_limit = $urandom_range(20, 3);
      endcase
      write_reg(LIMIT_ADDR, {16'($urandom), 16'(next_limit)});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        ticks_pending.push_back($urandom_range(99) < 80);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && refresh_frames_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
